// ===== hdl/pba_pkg.sv =====
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and codes of the power-of-two block allocator: controller
// states, result status codes, command codes, register indexes, payload
// widths and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package pba_pkg;

  // Request kinds carried in the input tuser bit
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic REG_REGION_BASE = 1'b0;
  localparam logic REG_TOP_LIMIT   = 1'b1;

  // Stream payload widths
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 40;

  // Result status codes
  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_EXHAUSTED = 2'd2,
    RES_FULL      = 2'd3
  } res_e;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_A_CHECK,
    ST_A_SCAN,
    ST_A_FRESH,
    ST_A_TAKE,
    ST_A_SPLIT,
    ST_F_START,
    ST_F_RD,
    ST_F_CMP,
    ST_F_CHK,
    ST_F_COMMIT,
    ST_DONE
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;          // latch the accepted transaction
    logic scan_step;     // advance the class scan
    logic pop;           // pop the current class stack (read issued)
    logic take_pop;      // take the popped block address
    logic take_fresh;    // take a fresh top block from the region
    logic split;         // push lower half, keep upper half
    logic used_wr_alloc; // record the allocated block
    logic used_rd;       // read the used table
    logic rd_last;       // read address is the last used entry
    logic srch_step;     // advance the search index
    logic found;         // latch class of the matching entry
    logic free_commit;   // remove the entry and push the block
    logic res_set;       // latch result status
    res_e res_code;
    logic out_load;      // load the output register
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_free;
    logic used_full;
    logic used_empty;
    logic cur_above;
    logic cur_nonempty;
    logic region_exh;
    logic cur_gt_k;
    logic match;
    logic idx_last;
    logic cls_full;
  } dp_stat_t;

endpackage

// ===== hdl/pba_ctrl.sv =====
// ----------------------------------------------------------------------------
// pba_ctrl
// Controller of the allocator: sequences the class scan, block split and
// used table search, and owns the stream handshakes.
// ----------------------------------------------------------------------------
module pba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  pba_pkg::dp_stat_t stat_i,
  output pba_pkg::dp_cmd_t  cmd_o
);
  import pba_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_code = RES_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d = ST_A_CHECK;
        end
      end
      ST_A_CHECK: begin
        if (stat_i.is_free) begin
          state_d = ST_F_START;
        end else if (stat_i.used_full) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = RES_FULL;
          state_d = ST_DONE;
        end else begin
          state_d = ST_A_SCAN;
        end
      end
      ST_A_SCAN: begin
        if (stat_i.cur_above) begin
          state_d = ST_A_FRESH;
        end else if (stat_i.cur_nonempty) begin
          cmd_o.pop = 1'b1;
          state_d = ST_A_TAKE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_A_FRESH: begin
        if (stat_i.region_exh) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = RES_EXHAUSTED;
          state_d = ST_DONE;
        end else begin
          cmd_o.take_fresh = 1'b1;
          state_d = ST_A_SPLIT;
        end
      end
      ST_A_TAKE: begin
        cmd_o.take_pop = 1'b1;
        state_d = ST_A_SPLIT;
      end
      ST_A_SPLIT: begin
        if (stat_i.cur_gt_k) begin
          cmd_o.split = 1'b1;
        end else begin
          cmd_o.used_wr_alloc = 1'b1;
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = RES_OK;
          state_d = ST_DONE;
        end
      end
      ST_F_START: begin
        if (stat_i.used_empty) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = RES_NOT_FOUND;
          state_d = ST_DONE;
        end else begin
          state_d = ST_F_RD;
        end
      end
      ST_F_RD: begin
        cmd_o.used_rd = 1'b1;
        state_d = ST_F_CMP;
      end
      ST_F_CMP: begin
        if (stat_i.match) begin
          cmd_o.found = 1'b1;
          state_d = ST_F_CHK;
        end else if (stat_i.idx_last) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = RES_NOT_FOUND;
          state_d = ST_DONE;
        end else begin
          cmd_o.srch_step = 1'b1;
          state_d = ST_F_RD;
        end
      end
      ST_F_CHK: begin
        if (stat_i.cls_full) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = RES_FULL;
          state_d = ST_DONE;
        end else begin
          cmd_o.used_rd = 1'b1;
          cmd_o.rd_last = 1'b1;
          state_d = ST_F_COMMIT;
        end
      end
      ST_F_COMMIT: begin
        cmd_o.free_commit = 1'b1;
        cmd_o.res_set  = 1'b1;
        cmd_o.res_code = RES_OK;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result until the downstream side takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;

endmodule

// ===== hdl/pba_datapath.sv =====
// ----------------------------------------------------------------------------
// pba_datapath
// Datapath of the allocator: configuration, class stack memory with its
// counts, used table memory, fresh block counter and the output register.
// ----------------------------------------------------------------------------
module pba_datapath #(
  parameter int unsigned FREE_DEPTH = 256,
  parameter int unsigned USED_DEPTH = 256,
  parameter int unsigned MIN_CLASS  = 5,
  parameter int unsigned MAX_CLASS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_cmd_i,
  input  logic [15:0]       in_size_i,
  input  logic [31:0]       in_addr_i,
  input  pba_pkg::dp_cmd_t  cmd_i,
  output pba_pkg::dp_stat_t stat_o,
  output logic [31:0]       out_addr_o,
  output logic [4:0]        out_class_o,
  output logic [1:0]        out_status_o
);
  import pba_pkg::*;

  localparam int unsigned NCLASS   = MAX_CLASS - MIN_CLASS + 1;
  localparam int unsigned CI_W     = $clog2(NCLASS + 1);
  localparam int unsigned CLS_W    = $clog2(NCLASS);
  localparam int unsigned FC_W     = $clog2(FREE_DEPTH + 1);
  localparam int unsigned SM_DEPTH = NCLASS * FREE_DEPTH;
  localparam int unsigned SM_AW    = $clog2(SM_DEPTH);
  localparam int unsigned UI_W     = $clog2(USED_DEPTH);
  localparam int unsigned UC_W     = $clog2(USED_DEPTH + 1);
  localparam int unsigned AW       = 32 - MIN_CLASS;
  localparam int unsigned UE_W     = AW + CLS_W;

  // Request size to class index: ceil(log2 size), clamped to the class range
  function automatic logic [CI_W-1:0] class_index(input logic [15:0] size);
    logic [15:0] m;
    logic [4:0]  lg;
    m  = size - 16'd1;
    lg = 5'd0;
    if (size > 16'd1) begin
      for (int b = 0; b < 16; b++) begin
        if (m[b]) lg = 5'(b + 1);
      end
    end
    if (int'(lg) <= int'(MIN_CLASS)) return '0;
    else if (int'(lg) >= int'(MAX_CLASS)) return CI_W'(NCLASS - 1);
    else return CI_W'(int'(lg) - int'(MIN_CLASS));
  endfunction

  logic [15:0]     base_q, limit_q, issued_q;
  logic            is_free_q;
  logic [CI_W-1:0] kidx_q, cur_q;
  logic [31:0]     addr_q;
  logic [FC_W-1:0] counts_q [NCLASS];
  logic [UC_W-1:0] used_cnt_q, idx_q;
  res_e            res_q;
  logic [31:0]     out_addr_q;
  logic [4:0]      out_class_q;
  logic [1:0]      out_status_q;

  logic [AW-1:0]   stack_mem [SM_DEPTH];
  logic [AW-1:0]   sm_rdata_q;
  logic [UE_W-1:0] used_mem [USED_DEPTH];
  logic [UE_W-1:0] used_rdata_q;

  logic [CLS_W-1:0] cur_cls, lo_cls, k_cls;
  logic [FC_W-1:0]  cur_cnt, lo_cnt, k_cnt;
  logic [SM_AW-1:0] sm_waddr, sm_raddr;
  logic             sm_we;
  logic [UI_W-1:0]  used_raddr, used_waddr;
  logic [UE_W-1:0]  used_wdata;
  logic             used_we;
  logic [31:0]      fresh_addr;
  logic [UC_W-1:0]  last_idx;

  assign cur_cls  = cur_q[CLS_W-1:0];
  assign lo_cls   = CLS_W'(cur_q - CI_W'(1));
  assign k_cls    = kidx_q[CLS_W-1:0];
  assign cur_cnt  = counts_q[cur_cls];
  assign lo_cnt   = counts_q[lo_cls];
  assign k_cnt    = counts_q[k_cls];
  assign last_idx = used_cnt_q - UC_W'(1);

  assign fresh_addr = {base_q, 16'd0} + (32'(issued_q) << MAX_CLASS);

  // Status toward the controller
  always_comb begin
    stat_o.is_free      = is_free_q;
    stat_o.used_full    = used_cnt_q >= UC_W'(USED_DEPTH);
    stat_o.used_empty   = used_cnt_q == '0;
    stat_o.cur_above    = cur_q >= CI_W'(NCLASS);
    stat_o.cur_nonempty = !stat_o.cur_above && (cur_cnt != '0);
    stat_o.region_exh   = issued_q >= limit_q;
    stat_o.cur_gt_k     = cur_q > kidx_q;
    stat_o.match        = (used_rdata_q[UE_W-1:CLS_W] == addr_q[31:MIN_CLASS]) &&
                          (addr_q[MIN_CLASS-1:0] == '0);
    stat_o.idx_last     = (idx_q + UC_W'(1)) == used_cnt_q;
    stat_o.cls_full     = k_cnt >= FC_W'(FREE_DEPTH);
  end

  // Stack memory addressing: one write port, one read port
  always_comb begin
    sm_we    = cmd_i.split || cmd_i.free_commit;
    sm_waddr = cmd_i.split ? SM_AW'(int'(lo_cls) * FREE_DEPTH + int'(lo_cnt))
                           : SM_AW'(int'(k_cls) * FREE_DEPTH + int'(k_cnt));
    sm_raddr = SM_AW'(int'(cur_cls) * FREE_DEPTH + int'(cur_cnt) - 1);
  end

  always_ff @(posedge clk_i) begin
    if (sm_we) stack_mem[sm_waddr] <= addr_q[31:MIN_CLASS];
    if (cmd_i.pop) sm_rdata_q <= stack_mem[sm_raddr];
  end

  // Used table addressing
  always_comb begin
    used_we    = cmd_i.used_wr_alloc || cmd_i.free_commit;
    used_waddr = cmd_i.used_wr_alloc ? used_cnt_q[UI_W-1:0] : idx_q[UI_W-1:0];
    used_wdata = cmd_i.used_wr_alloc ? {addr_q[31:MIN_CLASS], k_cls} : used_rdata_q;
    used_raddr = cmd_i.rd_last ? last_idx[UI_W-1:0] : idx_q[UI_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (used_we) used_mem[used_waddr] <= used_wdata;
    if (cmd_i.used_rd) used_rdata_q <= used_mem[used_raddr];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 16'd0;
      limit_q <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REGION_BASE: base_q  <= cfg_data_i;
        REG_TOP_LIMIT:   limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state: counts, fill level, fresh block counter, result status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCLASS; i++) counts_q[i] <= '0;
      used_cnt_q <= '0;
      issued_q   <= 16'd0;
      res_q      <= RES_OK;
    end else begin
      if (cmd_i.pop) counts_q[cur_cls] <= cur_cnt - FC_W'(1);
      if (cmd_i.split) counts_q[lo_cls] <= lo_cnt + FC_W'(1);
      if (cmd_i.free_commit) begin
        counts_q[k_cls] <= k_cnt + FC_W'(1);
        used_cnt_q      <= last_idx;
      end
      if (cmd_i.used_wr_alloc) used_cnt_q <= used_cnt_q + UC_W'(1);
      if (cmd_i.take_fresh) issued_q <= issued_q + 16'd1;
      if (cmd_i.res_set) res_q <= cmd_i.res_code;
    end
  end

  // Working registers of the transaction in flight
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_free_q <= in_cmd_i;
      addr_q    <= in_addr_i;
      kidx_q    <= class_index(in_size_i);
      cur_q     <= class_index(in_size_i);
      idx_q     <= '0;
    end
    if (cmd_i.scan_step) cur_q <= cur_q + CI_W'(1);
    if (cmd_i.take_pop) addr_q <= {sm_rdata_q, {MIN_CLASS{1'b0}}};
    if (cmd_i.take_fresh) begin
      addr_q <= fresh_addr;
      cur_q  <= CI_W'(NCLASS - 1);
    end
    if (cmd_i.split) begin
      addr_q <= addr_q + ((32'd1 << MIN_CLASS) << lo_cls);
      cur_q  <= cur_q - CI_W'(1);
    end
    if (cmd_i.srch_step) idx_q <= idx_q + UC_W'(1);
    if (cmd_i.found) kidx_q <= CI_W'(used_rdata_q[CLS_W-1:0]);
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_addr_q   <= (!is_free_q && res_q != RES_OK) ? 32'd0 : addr_q;
      out_class_q  <= (is_free_q && res_q == RES_NOT_FOUND) ? 5'd0
                                                            : 5'(int'(kidx_q) + MIN_CLASS);
      out_status_q <= res_q;
    end
  end

  assign out_addr_o   = out_addr_q;
  assign out_class_o  = out_class_q;
  assign out_status_o = out_status_q;

endmodule

// ===== hdl/pow2_block_allocator.sv =====
// ----------------------------------------------------------------------------
// pow2_block_allocator
// Power-of-two block allocator with one free stack per size class.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. An allocate checks the used table
// fill level, scans the classes upward from the requested one, pops a free
// block or takes a fresh top block from the region, splits it down to the
// requested class and records it in the used table. The scan and the split
// walk the class stack memory one step a cycle. A free searches the used
// table entry by entry up to the match, checks the class stack and commits.
// A free that finds nothing ends after the last entry, or without a search
// when the table is empty. Each entry searched takes a read state and a
// compare state, as the used table has a single read port. The result sits
// in an output register and the input is ready again in the cycle the result
// appears, so the next transaction is taken while the result waits. tuser
// carries the request kind (0 allocate, 1 free).
module pow2_block_allocator #(
  parameter int unsigned FREE_DEPTH = 256,
  parameter int unsigned USED_DEPTH = 256,
  parameter int unsigned MIN_CLASS  = 5,
  parameter int unsigned MAX_CLASS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // req_size[15:0], free_address[47:16]
  input  logic [0:0]  s_axis_tuser,  // cmd[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // block_address[31:0], size_class[36:32],
                                     // status[38:37], zero[39]
);
  import pba_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] out_addr;
  logic [4:0]  out_class;
  logic [1:0]  out_status;

  pba_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  pba_datapath #(
    .FREE_DEPTH (FREE_DEPTH),
    .USED_DEPTH (USED_DEPTH),
    .MIN_CLASS  (MIN_CLASS),
    .MAX_CLASS  (MAX_CLASS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_cmd_i     (s_axis_tuser[0]),
    .in_size_i    (s_axis_tdata[15:0]),
    .in_addr_i    (s_axis_tdata[47:16]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_addr_o   (out_addr),
    .out_class_o  (out_class),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {1'b0, out_status, out_class, out_addr};

  // One transaction in flight: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a transaction while one was in flight");

  // A successful result carries a class within range
  a_ok_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[38:37] == RES_OK |->
      m_axis_tdata[36:32] >= 5'(MIN_CLASS) && m_axis_tdata[36:32] <= 5'(MAX_CLASS))
    else $error("size class out of range on success");

  // Region exhaustion returns no address
  a_exh_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[38:37] == RES_EXHAUSTED |-> m_axis_tdata[31:0] == 32'd0)
    else $error("address given on region exhaustion");

endmodule

// ===== test/pow2_block_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// pow2_block_allocator_tb
// Self-checking testbench of the power-of-two block allocator. A directed
// table covers size extremes, exhaustion and bad frees. Then random allocate
// and free traffic runs under several region settings, with a flood that fills
// the used table and a class stack. Each result is compared with its typed row
// or with a behavioral allocator kept in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pow2_block_allocator_tb;
  import pba_pkg::*;

  localparam int unsigned MIN_C      = 5;
  localparam int unsigned MAX_C      = 16;
  localparam int unsigned STACK_D    = 256;
  localparam int unsigned TABLE_D    = 256;
  localparam int unsigned SETTLE     = 600;
  localparam int unsigned CYCLE_CAP  = 6000000;

  typedef struct packed {
    logic [31:0] addr;
    logic [4:0]  cls;
    res_e        st;
  } alloc_res_t;

  typedef enum logic [1:0] {ROW_ALLOC, ROW_FREE, ROW_SET_BASE, ROW_SET_LIMIT} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] size;
    logic [31:0] addr;   // free address, or register value
    logic        typed;
    alloc_res_t  want;
  } row_t;

  localparam alloc_res_t NONE = '{32'd0, 5'd0, RES_OK};
  localparam int unsigned N_ROWS = 24;
  localparam row_t DIRECTED [N_ROWS] = '{
    '{ROW_ALLOC, 16'd0,     32'd0,          1'b1, '{32'h0000FFE0, 5'd5, RES_OK}},
    '{ROW_ALLOC, 16'd32,    32'd0,          1'b0, NONE},
    '{ROW_ALLOC, 16'd33,    32'd0,          1'b0, NONE},
    '{ROW_ALLOC, 16'hFFFF,  32'd0,          1'b1, '{32'h00010000, 5'd16, RES_OK}},
    '{ROW_ALLOC, 16'h8001,  32'd0,          1'b1, '{32'h00020000, 5'd16, RES_OK}},
    '{ROW_ALLOC, 16'd1,     32'd0,          1'b0, NONE},
    '{ROW_ALLOC, 16'd64,    32'd0,          1'b0, NONE},
    '{ROW_ALLOC, 16'd65,    32'd0,          1'b0, NONE},
    '{ROW_ALLOC, 16'd4097,  32'd0,          1'b0, NONE},
    '{ROW_FREE,  16'd0,     32'h00012345,   1'b1, '{32'h00012345, 5'd0, RES_NOT_FOUND}},
    '{ROW_FREE,  16'hFFFF,  32'hFFFFFFFF,   1'b1, '{32'hFFFFFFFF, 5'd0, RES_NOT_FOUND}},
    '{ROW_FREE,  16'd0,     32'h00000000,   1'b1, '{32'h00000000, 5'd0, RES_NOT_FOUND}},
    '{ROW_FREE,  16'd0,     32'h00010000,   1'b1, '{32'h00010000, 5'd16, RES_OK}},
    '{ROW_FREE,  16'd0,     32'h00010000,   1'b1, '{32'h00010000, 5'd0, RES_NOT_FOUND}},
    '{ROW_FREE,  16'd0,     32'h0000FFE0,   1'b0, NONE},
    '{ROW_SET_LIMIT, 16'd0, 32'd0,          1'b0, NONE},
    '{ROW_ALLOC, 16'hFFFF,  32'd0,          1'b1, '{32'h00010000, 5'd16, RES_OK}},
    '{ROW_ALLOC, 16'hFFFF,  32'd0,          1'b1, '{32'h00000000, 5'd16, RES_EXHAUSTED}},
    '{ROW_ALLOC, 16'd0,     32'd0,          1'b0, NONE},
    '{ROW_SET_BASE,  16'd0, 32'h0000FFFF,   1'b0, NONE},
    '{ROW_SET_LIMIT, 16'd0, 32'h0000FFFF,   1'b0, NONE},
    '{ROW_ALLOC, 16'hFFFF,  32'd0,          1'b0, NONE},
    '{ROW_ALLOC, 16'd4096,  32'd0,          1'b0, NONE},
    '{ROW_FREE,  16'd0,     32'h00020000,   1'b0, NONE}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // req_size[15:0], free_address[47:16]
  logic [0:0]  s_axis_tuser;   // cmd[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // block_address[31:0], size_class[36:32], status[38:37]

  pow2_block_allocator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Allocator shadow state
  logic [31:0] stack_mem [MIN_C:MAX_C][STACK_D];
  int unsigned stack_cnt [MIN_C:MAX_C];
  logic [31:0] held_addr [TABLE_D];
  int unsigned held_cls  [TABLE_D];
  int unsigned held_cnt;
  int unsigned fresh_cnt;
  logic [15:0] base_page;
  logic [15:0] fresh_limit;

  alloc_res_t  pending_q [$];
  int unsigned snd_idle;
  int unsigned rcv_idle;
  int unsigned n_items;
  int unsigned n_results;
  int unsigned n_errors;
  int unsigned cycles;
  int unsigned cnt_by_status [4];

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("** pow2_block_allocator: FAILED **");
      $finish;
    end
  end

  function automatic alloc_res_t predict_alloc(input logic [15:0] size);
    int unsigned k;
    int unsigned c;
    int unsigned j;
    logic [31:0] a;
    alloc_res_t  r;
    k = MIN_C;
    while (k < MAX_C && (32'd1 << k) < size) k++;
    r = '{32'd0, 5'(k), RES_FULL};
    if (held_cnt >= TABLE_D) return r;
    c = k;
    while (c <= MAX_C && stack_cnt[c] == 0) c++;
    for (j = k; j < c && j <= MAX_C; j++)
      if (stack_cnt[j] >= STACK_D) return r;
    if (c > MAX_C) begin
      if (fresh_cnt >= fresh_limit) begin
        r.st = RES_EXHAUSTED;
        return r;
      end
      a = {base_page, 16'd0} + (fresh_cnt << MAX_C);
      fresh_cnt = (fresh_cnt + 1) & 32'hFFFF;
      c = MAX_C;
    end else begin
      stack_cnt[c]--;
      a = stack_mem[c][stack_cnt[c]];
    end
    // push each lower half, carry on with the upper one
    for (j = c; j > k; j--) begin
      stack_mem[j-1][stack_cnt[j-1]] = a;
      stack_cnt[j-1]++;
      a = a + (32'd1 << (j - 1));
    end
    held_addr[held_cnt] = a;
    held_cls[held_cnt]  = k;
    held_cnt++;
    r.addr = a;
    r.st   = RES_OK;
    return r;
  endfunction

  function automatic alloc_res_t predict_free(input logic [31:0] a);
    int unsigned i;
    int unsigned c;
    for (i = 0; i < held_cnt; i++)
      if (held_addr[i] == a) break;
    if (i >= held_cnt) return '{a, 5'd0, RES_NOT_FOUND};
    c = held_cls[i];
    if (stack_cnt[c] >= STACK_D) return '{a, 5'(c), RES_FULL};
    held_cnt--;
    held_addr[i] = held_addr[held_cnt];
    held_cls[i]  = held_cls[held_cnt];
    stack_mem[c][stack_cnt[c]] = a;
    stack_cnt[c]++;
    return '{a, 5'(c), RES_OK};
  endfunction

  // Offer one transaction, predict it once accepted
  task automatic send_req(input logic cmd, input logic [15:0] size, input logic [31:0] a,
                          input logic typed, input alloc_res_t want);
    alloc_res_t r;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {a, size};
    do @(posedge clk_i); while (!s_axis_tready);
    r = (cmd == CMD_ALLOC) ? predict_alloc(size) : predict_free(a);
    pending_q.push_back(typed ? want : r);
    n_items++;
  endtask

  // Drain outstanding results, then write a register
  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_REGION_BASE) base_page = val;
    else fresh_limit = val;
  endtask

  task automatic random_item();
    int unsigned pick;
    logic [15:0] size;
    logic [31:0] a;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      case ($urandom_range(0, 6))
        0, 1, 2, 3: size = 16'($urandom_range(0, 256));
        4, 5:       size = 16'($urandom_range(0, 4096));
        default:    size = 16'($urandom);
      endcase
      send_req(CMD_ALLOC, size, 32'($urandom), 1'b0, NONE);
    end else begin
      if (pick < 90 && held_cnt != 0) a = held_addr[$urandom_range(0, held_cnt - 1)];
      else if (pick < 95) a = $urandom;
      else a = {base_page, 16'd0} + ($urandom & 32'h000FFFE0);
      send_req(CMD_FREE, 16'($urandom), a, 1'b0, NONE);
    end
  endtask

  // Result checking
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);

  always @(posedge clk_i) begin
    alloc_res_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: tdata %h", m_axis_tdata);
        n_errors++;
      end else begin
        w = pending_q.pop_front();
        cnt_by_status[w.st]++;
        if (m_axis_tdata[31:0] !== w.addr) begin
          $error("block_address expected %h actual %h", w.addr, m_axis_tdata[31:0]);
          n_errors++;
        end
        if (m_axis_tdata[36:32] !== w.cls) begin
          $error("size_class expected %0d actual %0d", w.cls, m_axis_tdata[36:32]);
          n_errors++;
        end
        if (m_axis_tdata[38:37] !== w.st) begin
          $error("status expected %0d actual %0d", w.st, m_axis_tdata[38:37]);
          n_errors++;
        end
      end
    end
  end

  initial begin
    int unsigned ph;
    int unsigned i;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_REGION_BASE;
    cfg_data_i = 16'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_ALLOC;
    m_axis_tready = 1'b0;
    cycles = 0;
    n_items = 0;
    n_results = 0;
    n_errors = 0;
    cnt_by_status = '{0, 0, 0, 0};
    held_cnt = 0;
    fresh_cnt = 0;
    base_page = 16'd0;
    fresh_limit = 16'd256;
    foreach (stack_cnt[c]) stack_cnt[c] = 0;
    snd_idle = 21;
    rcv_idle = 74;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    foreach (DIRECTED[r]) begin
      case (DIRECTED[r].kind)
        ROW_ALLOC:     send_req(CMD_ALLOC, DIRECTED[r].size, DIRECTED[r].addr,
                                DIRECTED[r].typed, DIRECTED[r].want);
        ROW_FREE:      send_req(CMD_FREE, DIRECTED[r].size, DIRECTED[r].addr,
                                DIRECTED[r].typed, DIRECTED[r].want);
        ROW_SET_BASE:  write_reg(REG_REGION_BASE, DIRECTED[r].addr[15:0]);
        ROW_SET_LIMIT: write_reg(REG_TOP_LIMIT, DIRECTED[r].addr[15:0]);
        default: ;
      endcase
    end

    // Flood: fill the used table, then free into a full class stack
    write_reg(REG_REGION_BASE, 16'h0000);
    write_reg(REG_TOP_LIMIT, 16'd256);
    for (i = 0; i < 262; i++) send_req(CMD_ALLOC, 16'($urandom_range(0, 32)), 32'd0, 1'b0, NONE);
    for (i = 0; i < 262 && held_cnt != 0; i++)
      send_req(CMD_FREE, 16'd0, held_addr[$urandom_range(0, held_cnt - 1)], 1'b0, NONE);

    // Random traffic under three idle patterns and region settings
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          snd_idle = 21; rcv_idle = 74;
          write_reg(REG_REGION_BASE, 16'h0000);
          write_reg(REG_TOP_LIMIT, 16'd256);
        end
        1: begin
          snd_idle = 74; rcv_idle = 21;
          write_reg(REG_REGION_BASE, 16'hFFFF);
          write_reg(REG_TOP_LIMIT, 16'hFFFF);
        end
        default: begin
          snd_idle = 0; rcv_idle = 0;
          write_reg(REG_REGION_BASE, 16'h8A5C);
          write_reg(REG_TOP_LIMIT, 16'(fresh_cnt + 3));
        end
      endcase
      for (i = 0; i < 460; i++) random_item();
    end

    // Drain
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);

    $display("Ran %0d requests, %0d results: ok %0d, not found %0d, exhausted %0d, full %0d.",
             n_items, n_results, cnt_by_status[RES_OK], cnt_by_status[RES_NOT_FOUND],
             cnt_by_status[RES_EXHAUSTED], cnt_by_status[RES_FULL]);
    if (n_errors == 0) begin
      $display("** pow2_block_allocator: PASSED **");
    end else begin
      $display("** pow2_block_allocator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pba_pkg.sv
hdl/pba_ctrl.sv
hdl/pba_datapath.sv
hdl/pow2_block_allocator.sv
test/pow2_block_allocator_tb.sv
